FILE: hdl/ehr_pkg.sv
package ehr_pkg;

   localparam int DefaultHistoryDepth = 5;

   localparam int SampleWidth = 12;
   localparam int LevelWidth  = 8;
   localparam int RateWidth   = 16;
   localparam int HeartWidth  = 14;
   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 16;
   localparam int ReqDataWidth = 16;
   localparam int RspDataWidth = 24;

   localparam logic [LevelWidth-1:0] LevelBase     = 8'd207;
   localparam logic [HeartWidth-1:0] HeartRateMax  = 14'd16383;
   // 3277 / 65536 reproduces floor(x / 20) exactly for every 12-bit x.
   localparam logic [11:0]           LevelRecip20  = 12'd3277;

   localparam logic [7:0]  ThresholdReset   = 8'd50;
   localparam logic [15:0] IntervalMinReset = 16'd5;
   localparam logic [15:0] IntervalMaxReset = 16'd1000;
   localparam logic [15:0] RateScaleReset   = 16'd6000;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_LEVEL_THRESHOLD = 2'd0,
      CSR_INTERVAL_MIN    = 2'd1,
      CSR_INTERVAL_MAX    = 2'd2,
      CSR_RATE_SCALE      = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_RATE,
      S_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic load_sample;
      logic eval;
      logic ring_write;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic beat;
      logic div_done;
   } dp_status_type;

   function automatic logic [LevelWidth-1:0] sample_to_level(
      input logic [SampleWidth-1:0] sample
   );
      logic [23:0] product;
      begin
         product = 24'(sample) * 24'(LevelRecip20);
         return LevelBase - product[23:16];
      end
   endfunction

endpackage

FILE: hdl/ehr_div.sv
module ehr_div #(
   parameter int DIVIDEND_W = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [15:0]           divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CountW = $clog2(DIVIDEND_W + 1);

   logic [16:0]           rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [15:0]           dvs_ff, dvs_in;
   logic [CountW-1:0]     count_ff, count_in;
   logic                  done_ff, done_in;
   logic                  zero_ff, zero_in;
   logic [16:0]           rem_shift;
   logic                  fits;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      rem_shift = {rem_ff[15:0], quo_ff[DIVIDEND_W-1]};
      fits      = rem_shift >= {1'b0, dvs_ff};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      count_in  = count_ff;
      zero_in   = zero_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
         zero_in  = divisor == '0;
         count_in = CountW'(DIVIDEND_W);
      end else if (count_ff != '0) begin
         rem_in   = fits ? rem_shift - {1'b0, dvs_ff} : rem_shift;
         quo_in   = {quo_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff - 1'b1;
         done_in  = count_ff == CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      zero_ff <= zero_in;
   end

   assign done     = done_ff;
   assign quotient = zero_ff ? '0 : quo_ff;

endmodule

FILE: hdl/ehr_dp.sv
module ehr_dp #(
   parameter int HISTORY_DEPTH = ehr_pkg::DefaultHistoryDepth
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ehr_pkg::dp_cmd_type                   cmd,
   output ehr_pkg::dp_status_type                status,
   input  logic                                  csr_we,
   input  logic [ehr_pkg::CsrAddrWidth-1:0]      csr_addr,
   input  logic [ehr_pkg::CsrDataWidth-1:0]      csr_wdata,
   input  logic [ehr_pkg::SampleWidth-1:0]       adc_sample,
   output logic [ehr_pkg::HeartWidth-1:0]        rate_avg,
   output logic                                  beat_accepted,
   output logic [ehr_pkg::LevelWidth-1:0]        wave_level
);

   localparam int PtrW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int SumW = ehr_pkg::RateWidth + $clog2(HISTORY_DEPTH);
   localparam int LW   = ehr_pkg::LevelWidth;
   localparam int RW   = ehr_pkg::RateWidth;

   // The ring average is the sum times ceil(2^k / depth), keeping the bits above k.
   // With k = sum width + ceil(log2(depth)) this equals the integer quotient.
   localparam int RecipShift = SumW + $clog2(HISTORY_DEPTH);
   localparam int RecipW     = SumW + 1;
   localparam int ProdW      = RecipShift + SumW;
   localparam logic [RecipW-1:0] AvgRecip =
      RecipW'(((64'd1 << RecipShift) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

   logic [LW-1:0]    threshold_ff;
   logic [15:0]      int_min_ff, int_max_ff, scale_ff;

   logic [LW-1:0]    level_cur_ff, level_prev_ff, level_old_ff;
   logic [15:0]      interval_ff, interval_in;
   logic [PtrW-1:0]  ring_pos_ff, ring_pos_in;
   logic [RW-1:0]    ring_ff [HISTORY_DEPTH];
   logic [SumW-1:0]  sum_ff, sum_in;
   logic             accepted_ff;

   logic [ehr_pkg::HeartWidth-1:0] rate_out_ff;
   logic             beat_out_ff;
   logic [LW-1:0]    level_out_ff;

   logic             beat;
   logic             div_start;
   logic [15:0]      div_divisor;
   logic             div_done;
   logic [RW-1:0]    div_quotient;
   logic [RW-1:0]    new_rate;
   logic [ProdW-1:0] avg_product;
   logic [SumW-1:0]  avg_full;
   logic [ehr_pkg::HeartWidth-1:0] rate_avg_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ehr_pkg::ThresholdReset;
         int_min_ff   <= ehr_pkg::IntervalMinReset;
         int_max_ff   <= ehr_pkg::IntervalMaxReset;
         scale_ff     <= ehr_pkg::RateScaleReset;
      end else if (csr_we) begin
         unique case (ehr_pkg::csr_index_type'(csr_addr))
            ehr_pkg::CSR_LEVEL_THRESHOLD: threshold_ff <= csr_wdata[LW-1:0];
            ehr_pkg::CSR_INTERVAL_MIN:    int_min_ff   <= csr_wdata;
            ehr_pkg::CSR_INTERVAL_MAX:    int_max_ff   <= csr_wdata;
            ehr_pkg::CSR_RATE_SCALE:      scale_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The middle level is a local minimum below threshold, inside the interval window.
   assign beat = (level_prev_ff < level_old_ff) && (level_prev_ff < level_cur_ff) &&
                 (level_prev_ff < threshold_ff) &&
                 (interval_ff > int_min_ff) && (interval_ff < int_max_ff);

   assign div_start   = cmd.eval && beat;
   assign div_divisor = interval_ff;

   ehr_div #(
      .DIVIDEND_W(RW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (scale_ff),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign new_rate    = div_quotient;
   assign interval_in = (cmd.eval && beat) ? 16'd1 : interval_ff + 16'd1;
   assign ring_pos_in = (ring_pos_ff == PtrW'(HISTORY_DEPTH - 1)) ? '0
                                                                  : ring_pos_ff + 1'b1;
   assign sum_in      = sum_ff - SumW'(ring_ff[ring_pos_ff]) + SumW'(new_rate);

   assign avg_product  = ProdW'(sum_ff) * ProdW'(AvgRecip);
   assign avg_full     = avg_product[RecipShift +: SumW];
   assign rate_avg_sat = (avg_full > SumW'(ehr_pkg::HeartRateMax))
                         ? ehr_pkg::HeartRateMax : avg_full[ehr_pkg::HeartWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         level_prev_ff <= '0;
         level_old_ff  <= '0;
         interval_ff   <= '0;
         ring_pos_ff   <= '0;
         sum_ff        <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         if (cmd.eval) begin
            level_old_ff  <= level_prev_ff;
            level_prev_ff <= level_cur_ff;
            interval_ff   <= interval_in;
         end
         if (cmd.ring_write) begin
            ring_ff[ring_pos_ff] <= new_rate;
            ring_pos_ff          <= ring_pos_in;
            sum_ff               <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         level_cur_ff <= ehr_pkg::sample_to_level(adc_sample);
      end
      if (cmd.eval) begin
         accepted_ff <= beat;
      end
      if (cmd.out_load) begin
         rate_out_ff  <= rate_avg_sat;
         beat_out_ff  <= accepted_ff;
         level_out_ff <= level_cur_ff;
      end
   end

   assign status.beat     = beat;
   assign status.div_done = div_done;

   assign rate_avg      = rate_out_ff;
   assign beat_accepted = beat_out_ff;
   assign wave_level    = level_out_ff;

`ifndef SYNTH
   a_ring_pos_range: assert property (@(posedge clock) disable iff (reset)
      ring_pos_ff <= PtrW'(HISTORY_DEPTH - 1))
      else $error("ring position beyond history depth");
`endif

endmodule

FILE: hdl/ehr_ctrl.sv
module ehr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output ehr_pkg::dp_cmd_type    cmd,
   input  ehr_pkg::dp_status_type status
);

   ehr_pkg::ctrl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ehr_pkg::S_IDLE:   if (req_tvalid) state_in = ehr_pkg::S_EVAL;
         ehr_pkg::S_EVAL:   state_in = status.beat ? ehr_pkg::S_RATE : ehr_pkg::S_OUT;
         ehr_pkg::S_RATE:   if (status.div_done) state_in = ehr_pkg::S_OUT;
         ehr_pkg::S_OUT:    if (out_free) state_in = ehr_pkg::S_IDLE;
         default:           state_in = ehr_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ehr_pkg::S_IDLE: begin
            req_tready      = 1'b1;
            cmd.load_sample = req_tvalid;
         end
         ehr_pkg::S_EVAL:   cmd.eval       = 1'b1;
         ehr_pkg::S_RATE:   cmd.ring_write = status.div_done;
         ehr_pkg::S_OUT:    cmd.out_load   = out_free;
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ehr_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register loaded while a beat is pending");
   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ehr_pkg::S_IDLE && req_tvalid) |=> state_ff == ehr_pkg::S_EVAL)
      else $error("accepted sample not evaluated next cycle");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> state_ff == ehr_pkg::S_RATE)
      else $error("divider finished outside the wait state");
`endif

endmodule

FILE: hdl/ecg_heart_rate_estimator_core.sv
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tdata[11:0] adc_sample
// rsp      out        rsp_tvalid/rsp_tready  tdata[13:0] rate_avg, [14] beat_accepted,
//                                            [22:15] wave_level
// csr      in         csr_we                 csr_addr selects the register, csr_wdata
//
// A sample without a beat is evaluated the cycle after acceptance; its result is loaded
// once the response register is free, and the next sample is accepted after that load.
// A beat adds the serial division of scale by interval and a ring write before the load;
// the ring average is a combinational reciprocal multiply and adds no state.
// One sample in flight at a time; a held result blocks the next result load and sample.
// Reset is synchronous; it clears the ring, pointers and counters and sets CSR defaults.
module ecg_heart_rate_estimator_core #(
   parameter int HISTORY_DEPTH = ehr_pkg::DefaultHistoryDepth
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ehr_pkg::ReqDataWidth-1:0]   req_tdata,  // [11:0] adc_sample
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [13:0] rate_avg, [14] beat_accepted, [22:15] wave_level
   output logic [ehr_pkg::RspDataWidth-1:0]   rsp_tdata,
   input  logic                               csr_we,
   input  logic [ehr_pkg::CsrAddrWidth-1:0]   csr_addr,
   input  logic [ehr_pkg::CsrDataWidth-1:0]   csr_wdata
);

   ehr_pkg::dp_cmd_type            cmd;
   ehr_pkg::dp_status_type         status;
   logic [ehr_pkg::HeartWidth-1:0] rate_avg;
   logic                           beat_accepted;
   logic [ehr_pkg::LevelWidth-1:0] wave_level;

   ehr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   ehr_dp #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .adc_sample    (req_tdata[ehr_pkg::SampleWidth-1:0]),
      .rate_avg      (rate_avg),
      .beat_accepted (beat_accepted),
      .wave_level    (wave_level)
   );

   assign rsp_tdata = {1'b0, wave_level, beat_accepted, rate_avg};

endmodule
